// ===== hdl/md5cs_pkg.sv =====
// Package for the MD5 command-number seed pipeline: stage state type,
// chaining constants, round table and per-round helper functions.
// No dependencies.
`timescale 1ns / 1ps

package md5cs_pkg;

  localparam int NUM_ROUNDS = 64;

  localparam logic [31:0] IV_A      = 32'h67452301;
  localparam logic [31:0] IV_B      = 32'hefcdab89;
  localparam logic [31:0] IV_C      = 32'h98badcfe;
  localparam logic [31:0] IV_D      = 32'h10325476;
  localparam logic [31:0] PAD_WORD  = 32'h00000080;
  localparam logic [31:0] LEN_WORD  = 32'h00000020;
  localparam logic [3:0]  PAD_IDX   = 4'd1;
  localparam logic [3:0]  LEN_IDX   = 4'd14;
  localparam logic [3:0]  NUM_IDX   = 4'd0;

  localparam logic [1:0] PHASE_F = 2'd0;
  localparam logic [1:0] PHASE_G = 2'd1;
  localparam logic [1:0] PHASE_H = 2'd2;
  localparam logic [1:0] PHASE_I = 2'd3;

  localparam logic [31:0] K_TABLE [NUM_ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // State handed from one round cell to the next.
  typedef struct packed {
    logic        valid;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] num;
  } md5cs_state_t;

  function automatic logic [1:0] md5cs_phase(input int r);
    return 2'(r / 16);
  endfunction

  // Message word index used by round r.
  function automatic logic [3:0] md5cs_msg_idx(input int r);
    logic [1:0] ph;
    logic [3:0] rr;
    ph = md5cs_phase(r);
    rr = 4'(r);
    case (ph)
      PHASE_F: return rr;
      PHASE_G: return 4'(5 * rr + 1);
      PHASE_H: return 4'(3 * rr + 5);
      PHASE_I: return 4'(7 * rr);
      default: return rr;
    endcase
  endfunction

  function automatic logic [4:0] md5cs_rot(input int r);
    return ROT_TABLE[{md5cs_phase(r), 2'(r)}];
  endfunction

  // Fixed part of the padded block; word 0 carries the command number.
  function automatic logic [31:0] md5cs_const_word(input logic [3:0] idx);
    case (idx)
      PAD_IDX: return PAD_WORD;
      LEN_IDX: return LEN_WORD;
      default: return 32'h0;
    endcase
  endfunction

endpackage

// ===== hdl/md5cs_round_cell.sv =====
// One MD5 round as a registered cell of the pipeline chain.
// Depends on md5cs_pkg.
`timescale 1ns / 1ps

module md5cs_round_cell #(
  parameter int ROUND = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  md5cs_pkg::md5cs_state_t  st_i,
  output md5cs_pkg::md5cs_state_t  st_o
);
  import md5cs_pkg::*;

  localparam logic [1:0]  PHASE    = md5cs_phase(ROUND);
  localparam logic [3:0]  IDX      = md5cs_msg_idx(ROUND);
  localparam logic [4:0]  SH       = md5cs_rot(ROUND);
  localparam logic        USE_NUM  = (IDX == NUM_IDX);
  // Round constant already folded with the fixed message word.
  localparam logic [31:0] KM       = K_TABLE[ROUND] + md5cs_const_word(IDX);

  md5cs_state_t st_r, st_nxt;
  logic [31:0]  mix;
  logic [31:0]  sum;
  logic [31:0]  rot;

  always_comb begin
    case (PHASE)
      PHASE_F: mix = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
      PHASE_G: mix = (st_i.d & st_i.b) | (~st_i.d & st_i.c);
      PHASE_H: mix = st_i.b ^ st_i.c ^ st_i.d;
      PHASE_I: mix = st_i.c ^ (st_i.b | ~st_i.d);
      default: mix = 32'h0;
    endcase
  end

  assign sum = st_i.a + mix + KM + (USE_NUM ? st_i.num : 32'h0);
  assign rot = (sum << SH) | (sum >> (6'd32 - {1'b0, SH}));

  always_comb begin
    st_nxt.valid = st_i.valid;
    st_nxt.a     = st_i.d;
    st_nxt.b     = st_i.b + rot;
    st_nxt.c     = st_i.b;
    st_nxt.d     = st_i.c;
    st_nxt.num   = st_i.num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

// ===== hdl/md5cs_out_stage.sv =====
// Output register: final chaining add and seed extraction.
// Depends on md5cs_pkg.
`timescale 1ns / 1ps

module md5cs_out_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  md5cs_pkg::md5cs_state_t  st_i,
  output logic                     valid_o,
  output logic [30:0]              seed_o
);
  import md5cs_pkg::*;

  logic        valid_r;
  logic [30:0] seed_r, seed_nxt;
  logic [31:0] b_sum;
  logic [31:0] c_sum;

  assign b_sum    = st_i.b + IV_B;
  assign c_sum    = st_i.c + IV_C;
  // Digest bytes 6..9: upper half of b, then lower half of c, top bit dropped.
  assign seed_nxt = {c_sum[14:0], b_sum[31:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= st_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seed_r <= seed_nxt;
    end
  end

  assign valid_o = valid_r;
  assign seed_o  = seed_r;

endmodule

// ===== hdl/md5_counter_seed_top.sv =====
// Path: an accepted item passes through the 64 round cells, then 1 output register, to its seed.
// Throughput: one item per cycle; the whole chain advances together and holds only
// while a finished seed waits at the output under stall.
// Reset: synchronous, active low; clears the valid bits of every cell and the output.
// Depends on md5cs_pkg, md5cs_round_cell and md5cs_out_stage.
`timescale 1ns / 1ps

module md5_counter_seed_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_command_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_seed
);
  import md5cs_pkg::*;

  // The chain moves as one unit. It stops only when the output register holds
  // a seed that the receiver is stalling; empty slots are carried along as
  // bubbles, so no item is ever lost or doubled.
  logic         adv;
  md5cs_state_t chain [NUM_ROUNDS + 1];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // The head of the chain is the padded block's starting point: the standard
  // chaining values plus the command number, which is message word zero.
  always_comb begin
    chain[0].valid = in_valid && adv;
    chain[0].a     = IV_A;
    chain[0].b     = IV_B;
    chain[0].c     = IV_C;
    chain[0].d     = IV_D;
    chain[0].num   = in_command_number;
  end

  // One cell per MD5 round; each cell registers its result and hands it on.
  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
    md5cs_round_cell #(
      .ROUND (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .st_i  (chain[g]),
      .st_o  (chain[g + 1])
    );
  end

  // The last cell feeds the output register, which adds the chaining values
  // back in and picks the seed bytes out of the digest.
  md5cs_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .st_i    (chain[NUM_ROUNDS]),
    .valid_o (out_valid),
    .seed_o  (out_seed)
  );

endmodule

// ===== hdl/md5cs_checker.sv =====
// Port-level checker for the seed pipeline, bound to the top level.
// Depends on md5_counter_seed_top.
`timescale 1ns / 1ps

module md5cs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] out_seed
);

  // A seed under stall stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_seed))
    else $error("stalled seed changed or vanished");

  // Input is held back only by a seed that waits at the output.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting seed");

  // With the output free, input is never held back.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("seed shown after reset");

endmodule

bind md5_counter_seed_top md5cs_checker u_md5cs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_seed  (out_seed)
);
